/* rtl/bcrf_pkg.sv */
// Package for the batched-commit ring FIFO: sizes, function and status codes,
// and the command bundle from controller to datapath.
// No dependencies.
`timescale 1ns / 1ps

package bcrf_pkg;

  localparam int DEPTH     = 1024;
  localparam int CMD_WIDTH = 64;
  localparam int DATA_W    = 64;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = PTR_W + 1;
  localparam int NEST_W    = 8;

  typedef enum logic [2:0] {
    FN_PUSH        = 3'd0,
    FN_POP         = 3'd1,
    FN_BATCH_BEGIN = 3'd2,
    FN_BATCH_END   = 3'd3,
    FN_BATCH_RESET = 3'd4,
    FN_CLEAR       = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_INCONS = 2'd3
  } status_t;

  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply the captured item to the pointers and store
  } ctl_cmd_t;

endpackage

/* rtl/bcrf_ctrl.sv */
// Controller for the batched-commit ring FIFO: sequences capture, execute
// and respond for each item. Depends on bcrf_pkg.
`timescale 1ns / 1ps

module bcrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output bcrf_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_RESP;
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      valid_r <= (state_nxt == S_RESP);
    end
  end

  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);
  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

/* rtl/bcrf_datapath.sv */
// Datapath for the batched-commit ring FIFO: entry store, read/commit/write
// pointers, counts and batch depth. Depends on bcrf_pkg.
`timescale 1ns / 1ps

module bcrf_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bcrf_pkg::ctl_cmd_t              cmd,
  input  logic [2:0]                      in_func,
  input  logic [bcrf_pkg::DATA_W-1:0]     in_cmd_data,
  output logic [1:0]                      out_status,
  output logic [bcrf_pkg::DATA_W-1:0]     out_pop_data,
  output logic [bcrf_pkg::CNT_W-1:0]      out_committed_count,
  output logic [bcrf_pkg::CNT_W-1:0]      out_pending_count,
  output logic [bcrf_pkg::NEST_W-1:0]     out_batch_depth
);

  logic [bcrf_pkg::CMD_WIDTH-1:0] mem [bcrf_pkg::DEPTH];

  logic [2:0]                      func_r;
  logic [bcrf_pkg::DATA_W-1:0]     data_r;
  logic [bcrf_pkg::CMD_WIDTH-1:0]  rd_data_r;

  logic [bcrf_pkg::PTR_W-1:0]  read_ptr_r, read_ptr_nxt;
  logic [bcrf_pkg::PTR_W-1:0]  commit_ptr_r, commit_ptr_nxt;
  logic [bcrf_pkg::PTR_W-1:0]  write_ptr_r, write_ptr_nxt;
  logic [bcrf_pkg::CNT_W-1:0]  visible_r, visible_nxt;
  logic [bcrf_pkg::CNT_W-1:0]  stored_r, stored_nxt;
  logic [bcrf_pkg::NEST_W-1:0] nest_r, nest_nxt, nest_dec;
  bcrf_pkg::status_t           status_r, status_nxt;
  logic                        pop_ok_r, pop_ok_nxt;
  logic                        mem_we;

  logic [bcrf_pkg::PTR_W-1:0]  wr_inc;
  logic [bcrf_pkg::CNT_W-1:0]  sync_cnt, sync_cnt_inc;

  // ring distance wraps naturally at a power-of-two depth
  assign wr_inc       = write_ptr_r + 1'b1;
  assign sync_cnt     = {1'b0, bcrf_pkg::PTR_W'(write_ptr_r - read_ptr_r)};
  assign sync_cnt_inc = {1'b0, bcrf_pkg::PTR_W'(wr_inc - read_ptr_r)};
  assign nest_dec     = (nest_r == '0) ? '0 : nest_r - 1'b1;

  always_comb begin
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    write_ptr_nxt  = write_ptr_r;
    visible_nxt    = visible_r;
    stored_nxt     = stored_r;
    nest_nxt       = nest_r;
    status_nxt     = status_r;
    pop_ok_nxt     = pop_ok_r;
    mem_we         = 1'b0;
    if (cmd.exec) begin
      status_nxt = bcrf_pkg::ST_OK;
      pop_ok_nxt = 1'b0;
      case (func_r)
        bcrf_pkg::FN_PUSH: begin
          if (stored_r >= bcrf_pkg::CNT_W'(bcrf_pkg::DEPTH - 1)) begin
            // nearly full: force a batch reset and drop the item
            nest_nxt       = '0;
            commit_ptr_nxt = write_ptr_r;
            visible_nxt    = sync_cnt;
            stored_nxt     = sync_cnt;
            status_nxt     = bcrf_pkg::ST_FULL;
          end else begin
            mem_we        = 1'b1;
            write_ptr_nxt = wr_inc;
            stored_nxt    = stored_r + 1'b1;
            if (nest_r == '0) begin
              commit_ptr_nxt = wr_inc;
              visible_nxt    = sync_cnt_inc;
              stored_nxt     = sync_cnt_inc;
            end
          end
        end
        bcrf_pkg::FN_POP: begin
          if (visible_r == '0) begin
            status_nxt = bcrf_pkg::ST_EMPTY;
          end else if (read_ptr_r == commit_ptr_r &&
                       visible_r != bcrf_pkg::CNT_W'(bcrf_pkg::DEPTH)) begin
            visible_nxt = '0;
            status_nxt  = bcrf_pkg::ST_INCONS;
          end else begin
            pop_ok_nxt   = 1'b1;
            read_ptr_nxt = read_ptr_r + 1'b1;
            visible_nxt  = visible_r - 1'b1;
            if (stored_r != '0) stored_nxt = stored_r - 1'b1;
          end
        end
        bcrf_pkg::FN_BATCH_BEGIN: begin
          if (nest_r != '1) nest_nxt = nest_r + 1'b1;
        end
        bcrf_pkg::FN_BATCH_END: begin
          nest_nxt = nest_dec;
          if (nest_dec == '0) begin
            commit_ptr_nxt = write_ptr_r;
            visible_nxt    = sync_cnt;
            stored_nxt     = sync_cnt;
          end
        end
        bcrf_pkg::FN_BATCH_RESET: begin
          nest_nxt       = '0;
          commit_ptr_nxt = write_ptr_r;
          visible_nxt    = sync_cnt;
          stored_nxt     = sync_cnt;
        end
        bcrf_pkg::FN_CLEAR: begin
          read_ptr_nxt   = '0;
          commit_ptr_nxt = '0;
          write_ptr_nxt  = '0;
          visible_nxt    = '0;
          stored_nxt     = '0;
          nest_nxt       = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      write_ptr_r  <= '0;
      visible_r    <= '0;
      stored_r     <= '0;
      nest_r       <= '0;
      status_r     <= bcrf_pkg::ST_OK;
      pop_ok_r     <= 1'b0;
    end else begin
      read_ptr_r   <= read_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      write_ptr_r  <= write_ptr_nxt;
      visible_r    <= visible_nxt;
      stored_r     <= stored_nxt;
      nest_r       <= nest_nxt;
      status_r     <= status_nxt;
      pop_ok_r     <= pop_ok_nxt;
    end
  end

  // hold the captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      data_r <= in_cmd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[write_ptr_r] <= data_r[bcrf_pkg::CMD_WIDTH-1:0];
    if (cmd.exec) rd_data_r <= mem[read_ptr_r];
  end

  assign out_status          = status_r;
  assign out_pop_data        = pop_ok_r ? bcrf_pkg::DATA_W'(rd_data_r) : '0;
  assign out_committed_count = visible_r;
  assign out_pending_count   = stored_r;
  assign out_batch_depth     = nest_r;

endmodule

/* rtl/batched_commit_ring_fifo.sv */
// Top level of the batched-commit ring FIFO: controller plus datapath.
// Depends on bcrf_pkg, bcrf_ctrl and bcrf_datapath.
//
// Use: present in_func and in_cmd_data with start high; the item is taken at
// the clock edge where start is high and busy is low. Functions are push,
// pop, batch begin, batch end, batch reset and clear.
// Each item gives one result, shown for exactly one cycle with out_valid
// high, after it has passed through capture, execute and respond in turn.
// Busy stays high from the accepting edge until the result cycle ends, so a
// new item is taken only once the previous one has given its result.
// Pushes inside a batch stay invisible to pops until the batch closes.
// Reset clears pointers, counts and batch depth at once; the entry store is
// not cleared, and no pop can reach an entry that was never written.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`timescale 1ns / 1ps

module batched_commit_ring_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_func,
  input  logic [bcrf_pkg::DATA_W-1:0]     in_cmd_data,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [bcrf_pkg::DATA_W-1:0]     out_pop_data,
  output logic [bcrf_pkg::CNT_W-1:0]      out_committed_count,
  output logic [bcrf_pkg::CNT_W-1:0]      out_pending_count,
  output logic [bcrf_pkg::NEST_W-1:0]     out_batch_depth
);

  bcrf_pkg::ctl_cmd_t cmd;

  bcrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bcrf_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_func             (in_func),
    .in_cmd_data         (in_cmd_data),
    .out_status          (out_status),
    .out_pop_data        (out_pop_data),
    .out_committed_count (out_committed_count),
    .out_pending_count   (out_pending_count),
    .out_batch_depth     (out_batch_depth)
  );

endmodule

/* rtl/bcrf_checker.sv */
// Port-level checker for the batched-commit ring FIFO, bound to the top level.
// Depends on bcrf_pkg.
`timescale 1ns / 1ps

module bcrf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_status,
  input logic [bcrf_pkg::DATA_W-1:0] out_pop_data,
  input logic [bcrf_pkg::CNT_W-1:0]  out_committed_count,
  input logic [bcrf_pkg::CNT_W-1:0]  out_pending_count
);

  // every accepted item is answered by a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing after accepted item");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bcrf_pkg::ST_OK) |-> (out_pop_data == '0))
    else $error("pop data on failed operation");

  // visible entries never exceed stored ones
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_committed_count <= out_pending_count))
    else $error("committed count exceeds pending count");

endmodule

bind batched_commit_ring_fifo bcrf_checker u_bcrf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_pop_data        (out_pop_data),
  .out_committed_count (out_committed_count),
  .out_pending_count   (out_pending_count)
);

/* test/batched_commit_ring_fifo_tb.sv */
// Testbench for the batched-commit ring FIFO: directed, fill/saturation and random
// command traffic, each result checked against an in-bench predictor of the FIFO.
// Depends on bcrf_pkg and batched_commit_ring_fifo.
`timescale 1ns / 1ps

module batched_commit_ring_fifo_tb;
  import bcrf_pkg::*;

  typedef struct {
    status_t            status;
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   committed;
    logic [CNT_W-1:0]   pending;
    logic [NEST_W-1:0]  depth;
  } fifo_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [2:0]          in_func;
  logic [DATA_W-1:0]   in_cmd_data;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [DATA_W-1:0]   out_pop_data;
  logic [CNT_W-1:0]    out_committed_count;
  logic [CNT_W-1:0]    out_pending_count;
  logic [NEST_W-1:0]   out_batch_depth;

  // Predictor state
  logic [DATA_W-1:0]   fifo_words [DEPTH];
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    cm_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  int                  visible_cnt;
  int                  stored_cnt;
  logic [NEST_W-1:0]   nest_lvl;

  fifo_result_t        expected_results [$];
  int                  idle_pct;
  int                  items_sent;
  int                  results_checked;
  int                  rejected_pushes;
  int                  mismatches;

  batched_commit_ring_fifo i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_cmd_data         (in_cmd_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_pop_data        (out_pop_data),
    .out_committed_count (out_committed_count),
    .out_pending_count   (out_pending_count),
    .out_batch_depth     (out_batch_depth)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Commit the insertion pointer once no batch is open
  function automatic void commit_pending();
    if (nest_lvl == '0) begin
      cm_ptr      = wr_ptr;
      visible_cnt = (int'(wr_ptr) + DEPTH - int'(rd_ptr)) % DEPTH;
      stored_cnt  = visible_cnt;
    end
  endfunction

  function automatic fifo_result_t apply_command(input func_t fn, input logic [DATA_W-1:0] word);
    fifo_result_t res;
    res.status = ST_OK;
    res.data   = '0;
    case (fn)
      FN_PUSH: begin
        if (stored_cnt >= DEPTH - 1) begin
          nest_lvl = '0;
          commit_pending();
          res.status = ST_FULL;
        end else begin
          fifo_words[wr_ptr] = word;
          wr_ptr = wr_ptr + 1'b1;
          stored_cnt++;
          commit_pending();
        end
      end
      FN_POP: begin
        if (visible_cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (rd_ptr == cm_ptr && visible_cnt != DEPTH) begin
          visible_cnt = 0;
          res.status  = ST_INCONS;
        end else begin
          res.data = fifo_words[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          visible_cnt--;
          if (stored_cnt != 0) stored_cnt--;
        end
      end
      FN_BATCH_BEGIN: begin
        if (nest_lvl != '1) nest_lvl = nest_lvl + 1'b1;
      end
      FN_BATCH_END: begin
        if (nest_lvl != '0) nest_lvl = nest_lvl - 1'b1;
        commit_pending();
      end
      FN_BATCH_RESET: begin
        nest_lvl = '0;
        commit_pending();
      end
      FN_CLEAR: begin
        rd_ptr      = '0;
        cm_ptr      = '0;
        wr_ptr      = '0;
        visible_cnt = 0;
        stored_cnt  = 0;
        nest_lvl    = '0;
      end
      default: ;
    endcase
    res.committed = visible_cnt[CNT_W-1:0];
    res.pending   = stored_cnt[CNT_W-1:0];
    res.depth     = nest_lvl;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '1;
    if (pick < 15) return '0;
    return {$urandom, $urandom};
  endfunction

  // Offer one item, hold it until taken, and queue its expected result
  task automatic send_item(input func_t fn, input logic [DATA_W-1:0] word);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= fn;
    in_cmd_data <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_command(fn, word));
    if (fn == FN_PUSH && expected_results[$].status == ST_FULL) rejected_pushes++;
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_ops();
    send_item(FN_POP, '0);
    send_item(FN_PUSH, '0);
    send_item(FN_PUSH, '1);
    send_item(FN_PUSH, 64'h8000_0000_0000_0001);
    repeat (3) send_item(FN_POP, rand_word());
    send_item(FN_POP, '1);
    // batch end with no batch open still commits
    send_item(FN_BATCH_END, '0);
    send_item(FN_BATCH_BEGIN, '0);
    send_item(FN_PUSH, 64'h5555_aaaa_5555_aaaa);
    send_item(FN_POP, '0);
    send_item(FN_BATCH_BEGIN, '0);
    send_item(FN_BATCH_END, '0);
    send_item(FN_POP, '0);
    send_item(FN_BATCH_END, '0);
    send_item(FN_POP, '0);
    send_item(FN_BATCH_BEGIN, '0);
    send_item(FN_PUSH, 64'haaaa_5555_aaaa_5555);
    send_item(FN_BATCH_RESET, '1);
    send_item(FN_POP, '0);
    send_item(FN_PUSH, rand_word());
    send_item(FN_CLEAR, '1);
    send_item(FN_POP, '0);
  endtask

  // Fill to the full threshold inside nested batches, saturating the depth,
  // then drain and refill a little so the pointers wrap
  task automatic test_fill_and_saturate();
    int begins;
    begins = 0;
    send_item(FN_CLEAR, rand_word());
    while (stored_cnt < DEPTH - 1) begin
      if (begins < 258 && $urandom_range(99) < 25) begin
        send_item(FN_BATCH_BEGIN, rand_word());
        begins++;
      end else begin
        send_item(FN_PUSH, rand_word());
      end
    end
    repeat (258 - begins) send_item(FN_BATCH_BEGIN, rand_word());
    send_item(FN_POP, rand_word());
    send_item(FN_BATCH_END, rand_word());
    send_item(FN_BATCH_BEGIN, rand_word());
    send_item(FN_PUSH, rand_word());
    send_item(FN_PUSH, rand_word());
    repeat (12) send_item(FN_POP, rand_word());
    repeat (12) send_item(FN_PUSH, rand_word());
  endtask

  task automatic test_random_traffic(input int pct, input int count);
    int pick;
    idle_pct = pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 42)      send_item(FN_PUSH, rand_word());
      else if (pick < 80) send_item(FN_POP, rand_word());
      else if (pick < 88) send_item(FN_BATCH_BEGIN, rand_word());
      else if (pick < 95) send_item(FN_BATCH_END, rand_word());
      else if (pick < 98) send_item(FN_BATCH_RESET, rand_word());
      else                send_item(FN_CLEAR, rand_word());
    end
  endtask

  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_pop_data !== want.data) begin
          $error("pop_data: expected %h, got %h", want.data, out_pop_data);
          mismatches++;
        end
        if (out_committed_count !== want.committed) begin
          $error("committed_count: expected %0d, got %0d", want.committed,
                 out_committed_count);
          mismatches++;
        end
        if (out_pending_count !== want.pending) begin
          $error("pending_count: expected %0d, got %0d", want.pending, out_pending_count);
          mismatches++;
        end
        if (out_batch_depth !== want.depth) begin
          $error("batch_depth: expected %0d, got %0d", want.depth, out_batch_depth);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_func         <= FN_PUSH;
    in_cmd_data     <= '0;
    idle_pct        = 18;
    items_sent      = 0;
    results_checked = 0;
    rejected_pushes = 0;
    mismatches      = 0;
    rd_ptr          = '0;
    cm_ptr          = '0;
    wr_ptr          = '0;
    visible_cnt     = 0;
    stored_cnt      = 0;
    nest_lvl        = '0;
    foreach (fifo_words[i]) fifo_words[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_fill_and_saturate();
    test_random_traffic(18, 40);
    wait_drained();
    test_random_traffic(63, 40);
    wait_drained();
    test_random_traffic(0, 40);
    wait_drained();
    repeat (6) @(posedge clk);

    $display("Covered %0d items (directed, fill with depth saturation, random traffic);",
             items_sent);
    $display("%0d results compared, %0d pushes rejected at the full threshold.",
             results_checked, rejected_pushes);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
